[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[hdl/gf2rb_pkg.sv]
// Package with shared types and constants of the GF(2) rank basis block.
package gf2rb_pkg;

	// Fixed field widths of the stream items and the config register
	localparam int COL_W      = 10;
	localparam int DIM_W      = 4;
	localparam int RANK_OUT_W = 4;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 8;

	localparam logic [DIM_W-1:0]      DIM_RESET    = 4'd10;
	localparam logic [RANK_OUT_W-1:0] RANK_OUT_MAX = '1;

	// Control bits that travel with a column down the chain
	typedef struct packed {
		logic valid;
		logic start;
		logic indep;
	} gf2rb_ctl_t;

endpackage

[hdl/gf2rb_cell.sv]
// One pivot cell: holds the basis slot for one leading-bit position.
module gf2rb_cell #(
	parameter int VEC_WIDTH = 10,
	parameter int K         = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [VEC_WIDTH-1:0]   vec_in,
	input  gf2rb_pkg::gf2rb_ctl_t  ctl_in,
	output logic [VEC_WIDTH-1:0]   vec_out,
	output gf2rb_pkg::gf2rb_ctl_t  ctl_out
);

	logic [VEC_WIDTH-1:0]  slot_q;
	logic [VEC_WIDTH-1:0]  slot_eff;
	logic [VEC_WIDTH-1:0]  vec_nxt;
	logic [VEC_WIDTH-1:0]  vec_s1;
	logic                  hit;
	logic                  insert;
	gf2rb_pkg::gf2rb_ctl_t ctl_nxt;
	gf2rb_pkg::gf2rb_ctl_t ctl_s1;

	// Drop the slot when this item opens a new set
	assign slot_eff = ctl_in.start ? '0 : slot_q;

	// Reduce on a set top bit, or claim the empty slot
	always_comb begin
		hit     = ctl_in.valid && !ctl_in.indep && vec_in[K];
		insert  = hit && (slot_eff == '0);
		vec_nxt = (hit && !insert) ? (vec_in ^ slot_eff) : vec_in;
		ctl_nxt = ctl_in;
		ctl_nxt.indep = ctl_in.indep | insert;
	end

	// Update the slot as an item passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (en && ctl_in.valid) begin
			slot_q <= insert ? vec_in : slot_eff;
		end
	end

	// Hand the item to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_nxt;
		end
	end

	assign vec_out = vec_s1;
	assign ctl_out = ctl_s1;

endmodule

[hdl/gf2rb_rank.sv]
// Rank counter and output register at the end of the cell chain.
module gf2rb_rank #(
	parameter int VEC_WIDTH = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  gf2rb_pkg::gf2rb_ctl_t              ctl_in,
	input  logic [gf2rb_pkg::DIM_W-1:0]        syndrome_dim,
	output logic                               m_tvalid,
	output logic [gf2rb_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam int RANK_W = $clog2(VEC_WIDTH + 1);
	localparam int CMP_W  = (RANK_W > gf2rb_pkg::DIM_W) ? RANK_W : gf2rb_pkg::DIM_W;
	localparam int PAD_W  = gf2rb_pkg::M_TDATA_W - gf2rb_pkg::RANK_OUT_W - 2;

	logic [RANK_W-1:0]                rank_q;
	logic [RANK_W-1:0]                rank_nxt;
	logic [gf2rb_pkg::RANK_OUT_W-1:0] rank_sat;
	logic                             over_nxt;
	logic                             tvalid_q;
	logic [gf2rb_pkg::M_TDATA_W-1:0]  tdata_q;

	// Count inserted columns, restart on a new set
	always_comb begin
		rank_nxt = ctl_in.start ? RANK_W'(ctl_in.indep)
		                        : rank_q + RANK_W'(ctl_in.indep);
		over_nxt = CMP_W'(rank_nxt) > CMP_W'(syndrome_dim);
		if (CMP_W'(rank_nxt) > CMP_W'(gf2rb_pkg::RANK_OUT_MAX)) begin
			rank_sat = gf2rb_pkg::RANK_OUT_MAX;
		end else begin
			rank_sat = gf2rb_pkg::RANK_OUT_W'(rank_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= '0;
			tvalid_q <= 1'b0;
		end else if (en) begin
			tvalid_q <= ctl_in.valid;
			if (ctl_in.valid) begin
				rank_q <= rank_nxt;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (en && ctl_in.valid) begin
			tdata_q <= {PAD_W'(0), over_nxt, ctl_in.indep, rank_sat};
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

[hdl/gf2_rank_basis_top.sv]
// Top level of the GF(2) rank basis block: input stage, cell chain, rank output.
//
// channel | direction | handshake            | payload
// s_*     | in        | s_tvalid / s_tready  | s_tdata: column; s_tuser: start_req
// m_*     | out       | m_tvalid / m_tready  | m_tdata: rank, independent, over_dim
// cfg_*   | in        | cfg_valid / cfg_ready| cfg_data: syndrome_dim
//
// One column enters per cycle while the chain is not stalled; each result passes through
// one register per pivot cell in the chain and then the rank register.
// Reset clears every basis slot, the rank and all valid bits; syndrome_dim goes to 10.
// A result that is not taken stalls the whole chain; s_tready follows it.
// cfg_ready is always high.
module gf2_rank_basis_top #(
	parameter int VEC_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gf2rb_pkg::S_TDATA_W-1:0]   s_tdata,  // [9:0] column, [15:10] zero
	input  logic                              s_tuser,  // [0] start_req
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gf2rb_pkg::M_TDATA_W-1:0]   m_tdata,  // [3:0] rank, [4] independent,
	                                                    // [5] over_dim, [7:6] zero
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gf2rb_pkg::DIM_W-1:0]       cfg_data
);

	logic                        en;
	logic [gf2rb_pkg::DIM_W-1:0] syndrome_dim_q;
	logic [VEC_WIDTH-1:0]        vec   [0:VEC_WIDTH];
	gf2rb_pkg::gf2rb_ctl_t       ctl   [0:VEC_WIDTH];

	// Advance the chain whenever the output register can take a result
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Hold the dimension limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syndrome_dim_q <= gf2rb_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			syndrome_dim_q <= cfg_data;
		end
	end

	// Mask the column to the vector width and mark it as a fresh item
	assign vec[0] = VEC_WIDTH'(s_tdata[gf2rb_pkg::COL_W-1:0]);
	assign ctl[0] = '{valid: s_tvalid, start: s_tuser, indep: 1'b0};

	// Chain of pivot cells, top bit first
	for (genvar i = 0; i < VEC_WIDTH; i++) begin : g_cell
		gf2rb_cell #(
			.VEC_WIDTH (VEC_WIDTH),
			.K         (VEC_WIDTH - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vec_in  (vec[i]),
			.ctl_in  (ctl[i]),
			.vec_out (vec[i+1]),
			.ctl_out (ctl[i+1])
		);
	end

	gf2rb_rank #(
		.VEC_WIDTH (VEC_WIDTH)
	) u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctl_in       (ctl[VEC_WIDTH]),
		.syndrome_dim (syndrome_dim_q),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata)
	);

endmodule

[hdl/gf2rb_checker.sv]
// Port-level checker for the GF(2) rank basis top level, with its bind.
`include "assert_macros.svh"

module gf2rb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [gf2rb_pkg::M_TDATA_W-1:0]  m_tdata
);

	// A waiting result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// An independent column leaves a nonzero rank
	`ASSERT_IMPL(a_indep_rank, clk, arst_n, m_tvalid && m_tdata[4], m_tdata[3:0] != 4'd0)
	// An empty basis never exceeds the limit
	`ASSERT_IMPL(a_zero_rank, clk, arst_n, m_tvalid && m_tdata[3:0] == 4'd0, !m_tdata[5])
	// An empty output stage always takes a column
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind gf2_rank_basis_top gf2rb_checker u_gf2rb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/gf2_rank_basis_top_tb.sv]
// Testbench for gf2_rank_basis_top: queued column sets, handshake driver, result monitor.
module gf2_rank_basis_top_tb;

	localparam int VEC_W       = gf2rb_pkg::COL_W;
	localparam int LATENCY     = VEC_W + 1;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	// One column waiting to be sent; drain holds it back until all results are in
	typedef struct {
		logic [VEC_W-1:0] col;
		logic             start;
		logic             drain;
	} col_item_t;

	typedef struct {
		logic [gf2rb_pkg::RANK_OUT_W-1:0] rank;
		logic                             independent;
		logic                             over_dim;
	} rank_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [gf2rb_pkg::S_TDATA_W-1:0] s_tdata = '0;  // [9:0] column, [15:10] zero
	logic s_tuser = 1'b0;                           // [0] start_req
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [gf2rb_pkg::M_TDATA_W-1:0] m_tdata;       // [3:0] rank, [4] independent,
	                                                // [5] over_dim, [7:6] zero
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gf2rb_pkg::DIM_W-1:0] cfg_data = '0;

	// Predicted block state
	logic [VEC_W-1:0] basis_slots [VEC_W];
	int unsigned rank_now;
	logic [gf2rb_pkg::DIM_W-1:0] dim_now;

	col_item_t col_items_pending[$];
	rank_result_t rank_results_due[$];
	col_item_t cur_col;
	logic have_cur = 1'b0;
	rank_result_t want;

	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	gf2_rank_basis_top #(
		.VEC_WIDTH(VEC_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Reduce one column against the predicted basis, insert it if independent, return the result
	function automatic rank_result_t rank_after_column(logic [VEC_W-1:0] col, logic start);
		rank_result_t r;
		logic [VEC_W-1:0] v;
		bit placed;
		if (start) begin
			foreach (basis_slots[k])
				basis_slots[k] = '0;
			rank_now = 0;
		end
		v = col;
		placed = 1'b0;
		for (int k = VEC_W - 1; k >= 0; k--) begin
			if (!placed && v[k]) begin
				if (basis_slots[k] != '0) begin
					v ^= basis_slots[k];
				end else begin
					basis_slots[k] = v;
					rank_now++;
					placed = 1'b1;
				end
			end
		end
		r.rank = (rank_now > gf2rb_pkg::RANK_OUT_MAX) ? gf2rb_pkg::RANK_OUT_MAX
			: gf2rb_pkg::RANK_OUT_W'(rank_now);
		r.independent = placed;
		r.over_dim = (rank_now > dim_now);
		return r;
	endfunction

	task automatic queue_column(logic [VEC_W-1:0] col, logic start, logic drain);
		col_item_t it;
		it.col = col;
		it.start = start;
		it.drain = drain;
		col_items_pending = {col_items_pending, it};
	endtask

	// Mostly well-formed sets that open with a start, with dependent, zero and unit columns
	task automatic queue_random_sets(int n_items, int drain_at);
		logic [VEC_W-1:0] set_cols[$];
		logic [VEC_W-1:0] col;
		logic start;
		int set_len;
		int pushed;
		pushed = 0;
		while (pushed < n_items) begin
			set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24)
				: $urandom_range(1, 14);
			set_cols.delete();
			for (int i = 0; i < set_len && pushed < n_items; i++) begin
				start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
				case ($urandom_range(0, 9))
					0: col = '0;
					1: col = VEC_W'(1) << $urandom_range(0, VEC_W - 1);
					2, 3: begin
						col = '0;
						foreach (set_cols[j])
							if ($urandom_range(0, 1) == 1)
								col ^= set_cols[j];
					end
					default: col = VEC_W'($urandom);
				endcase
				set_cols = {set_cols, col};
				queue_column(col, start, pushed == drain_at);
				pushed++;
			end
		end
	endtask

	// Block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		while (!(col_items_pending.size() == 0 && !have_cur && rank_results_due.size() == 0))
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_syndrome_dim(logic [gf2rb_pkg::DIM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		dim_now = v;
	endtask

	// Driver: predict on acceptance, then offer the next column or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				rank_results_due = {rank_results_due,
					rank_after_column(cur_col.col, cur_col.start)};
				have_cur = 1'b0;
			end
			if (!have_cur && col_items_pending.size() != 0 &&
			    (!col_items_pending[0].drain || rank_results_due.size() == 0)) begin
				cur_col = col_items_pending.pop_front();
				have_cur = 1'b1;
			end
			if (!have_cur) begin
				s_tvalid <= 1'b0;
			end else if ((s_tvalid && !s_tready) ||
			             $urandom_range(0, 99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {{(gf2rb_pkg::S_TDATA_W - VEC_W){1'b0}}, cur_col.col};
				s_tuser <= cur_col.start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each taken result with the oldest prediction, then pick ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (rank_results_due.size() == 0) begin
					$error("result with no column outstanding: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = rank_results_due.pop_front();
					if (m_tdata[3:0] !== want.rank) begin
						$error("rank: expected %0d, actual %0d", want.rank, m_tdata[3:0]);
						mismatches++;
					end
					if (m_tdata[4] !== want.independent) begin
						$error("independent: expected %0d, actual %0d", want.independent,
							m_tdata[4]);
						mismatches++;
					end
					if (m_tdata[5] !== want.over_dim) begin
						$error("over_dim: expected %0d, actual %0d", want.over_dim, m_tdata[5]);
						mismatches++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gf2_rank_basis_top: mismatch");
			$finish;
		end
	end

	initial begin
		foreach (basis_slots[k])
			basis_slots[k] = '0;
		rank_now = 0;
		dim_now = gf2rb_pkg::DIM_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles less than the receiver
		sender_idle_pct = 35;
		recv_idle_pct = 61;

		// Directed: zero and full columns, repeats, every unit vector, restarts
		queue_column(10'h001, 1'b0, 1'b0);
		queue_column(10'h000, 1'b0, 1'b0);
		queue_column(10'h3FF, 1'b0, 1'b0);
		queue_column(10'h3FF, 1'b0, 1'b0);
		queue_column(10'h000, 1'b1, 1'b0);
		for (int k = VEC_W - 1; k >= 0; k--)
			queue_column(VEC_W'(1) << k, 1'b0, 1'b0);
		queue_column(10'h155, 1'b0, 1'b0);
		queue_column(10'h000, 1'b0, 1'b0);
		queue_column(10'h3FF, 1'b1, 1'b0);
		queue_column(10'h2AA, 1'b0, 1'b0);
		queue_column(10'h155, 1'b0, 1'b0);
		queue_column(10'h3FF, 1'b0, 1'b0);
		wait_idle();

		write_syndrome_dim(4'd0);
		queue_random_sets(100, -1);
		wait_idle();

		// Sender pauses mid-phase until every result is back
		write_syndrome_dim(4'd15);
		queue_random_sets(100, 50);
		wait_idle();

		// Sender idles more, with one long receiver hold-off that backs up the chain
		sender_idle_pct = 61;
		recv_idle_pct = 35;
		write_syndrome_dim(4'd4);
		hold_requests++;
		queue_random_sets(100, -1);
		wait_idle();

		write_syndrome_dim(4'd9);
		queue_random_sets(100, -1);
		wait_idle();

		// Full rate on both sides
		sender_idle_pct = 0;
		recv_idle_pct = 0;
		write_syndrome_dim(gf2rb_pkg::DIM_W'($urandom_range(0, 15)));
		queue_random_sets(100, -1);
		wait_idle();

		write_syndrome_dim(4'd10);
		queue_random_sets(100, -1);
		wait_idle();

		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("gf2_rank_basis_top: match");
		else
			$display("gf2_rank_basis_top: mismatch");
		$finish;
	end

endmodule

[gf2_rank_basis_top.f]
+incdir+hdl
hdl/gf2rb_pkg.sv
hdl/gf2rb_cell.sv
hdl/gf2rb_rank.sv
hdl/gf2_rank_basis_top.sv
hdl/gf2rb_checker.sv
tb/gf2_rank_basis_top_tb.sv
